// ----- hw/rtl/qsj_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the quad surface Jacobian block.
// Used by the controller, the datapath and the top level; depends on nothing.
package qsj_pkg;

    localparam int QSJ_NUM_QP   = 4;
    localparam int QP_W         = 17;
    localparam int NUM_CFG      = 8;
    localparam int CFG_IDX_W    = 3;

    localparam logic [QP_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [QP_W-1:0] QP_RESET [NUM_CFG] = '{
        17'd13849, 17'd13849, 17'd51687, 17'd13849,
        17'd51687, 17'd51687, 17'd13849, 17'd51687
    };

    localparam int MULA_STEPS = 16;
    localparam int CROSS_STEPS = 6;
    localparam int SQ_STEPS   = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int LAST_COMP  = 2;

    typedef struct packed {
        logic       node_load;
        logic       diff_load;
        logic       mula_go;
        logic [3:0] mula_step;
        logic       abs_a;
        logic       shift_a;
        logic       cross_go;
        logic [2:0] cross_step;
        logic       abs_c;
        logic       shr_c;
        logic       shl_c;
        logic       sq_go;
        logic [1:0] sq_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       nrm_store;
        logic [1:0] div_comp;
        logic       area_go;
        logic       out_load;
        logic [1:0] qp;
        logic       last;
    } qsj_cmd_t;

    typedef struct packed {
        logic a_big;
        logic c_big;
        logic c_small;
        logic c_zero;
    } qsj_status_t;

endpackage

// ----- hw/rtl/qsj_sqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
// Stand-alone unit; stepped by the datapath under controller command.
module qsj_sqrt (
    input  logic        clk,
    input  logic        init,
    input  logic        step,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (step)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// ----- hw/rtl/qsj_div.sv -----
`timescale 1ns / 1ps
// Restoring divider: 62-bit dividend by 32-bit divisor, 31 quotient bits.
// Stand-alone unit; the dividend must be below the divisor times 2^31.
module qsj_div (
    input  logic        clk,
    input  logic        init,
    input  logic        step,
    input  logic [61:0] num,
    input  logic [31:0] den,
    output logic [30:0] quot
);

    logic [31:0] rem_reg;
    logic [30:0] lo_reg;
    logic [30:0] q_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, lo_reg[30]};
    assign fits  = trial >= {1'b0, den};
    assign quot  = q_reg;

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            rem_reg <= {1'b0, num[61:31]};
            lo_reg  <= num[30:0];
            q_reg   <= '0;
        end
        else if (step)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
            lo_reg  <= {lo_reg[29:0], 1'b0};
            q_reg   <= {q_reg[29:0], fits};
        end
    end

endmodule

// ----- hw/rtl/qsj_dp.sv -----
`timescale 1ns / 1ps
// Datapath: node store, quadrature registers, shared multipliers, normalizing
// shifters, result registers. Depends on qsj_pkg, qsj_sqrt and qsj_div.
module qsj_dp
    import qsj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [QP_W-1:0]       cfg_data,
    input  logic [1:0]            node_index,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    input  qsj_cmd_t              cmd,
    output qsj_status_t           status,
    output logic [1:0]            point_index,
    output logic [QP_W-1:0]       basis_0,
    output logic [QP_W-1:0]       basis_1,
    output logic [QP_W-1:0]       basis_2,
    output logic [QP_W-1:0]       basis_3,
    output logic signed [31:0]    normal_x,
    output logic signed [31:0]    normal_y,
    output logic signed [31:0]    normal_z,
    output logic [63:0]           area_scale,
    output logic                  degenerate,
    output logic                  last
);

    logic [QP_W-1:0]     qp_reg [NUM_CFG];
    logic signed [31:0]  node_reg [4][3];
    logic signed [32:0]  e10_reg [3];
    logic signed [32:0]  e23_reg [3];
    logic signed [32:0]  e30_reg [3];
    logic signed [32:0]  e21_reg [3];

    logic [QP_W-1:0]     raw_r, raw_s, r_val, s_val, rc_val, sc_val;

    logic [1:0]          ka;
    logic [QP_W-1:0]     coef_a;
    logic signed [33:0]  opd_a;
    logic signed [51:0]  prod_a;
    logic signed [51:0]  prod_a_reg;
    logic signed [51:0]  prod_rnd;
    logic                prod_a_vld_reg;
    logic [3:0]          prod_a_step_reg;

    logic signed [51:0]  dv_reg [6];
    logic [50:0]         am_reg [6];
    logic                asg_reg [6];
    logic [4:0]          a_reg;
    logic [QP_W-1:0]     basis_reg [4];

    logic signed [31:0]  uv [3];
    logic signed [31:0]  wv [3];
    logic signed [31:0]  op_u, op_w;
    logic signed [63:0]  prod_b;
    logic signed [63:0]  prod_b_reg;
    logic                prod_b_vld_reg;
    logic                prod_b_sq_reg;
    logic [2:0]          prod_b_step_reg;

    logic signed [63:0]  c_reg [3];
    logic [61:0]         cm_reg [3];
    logic                csg_reg [3];
    logic signed [6:0]   b_reg;
    logic [63:0]         sum_reg;

    logic [31:0]         root;
    logic [61:0]         div_num;
    logic [30:0]         quot;
    logic signed [31:0]  nrm_reg [3];
    logic [63:0]         area_reg;
    logic                degen_reg;

    logic signed [7:0]   e_val;
    logic [5:0]          rsh;
    logic [63:0]         rnd_sum;
    logic [95:0]         lsh;
    logic [63:0]         area_val;

    function automatic logic signed [31:0] sm32(input logic sg, input logic [29:0] mg);
        logic [31:0] v;
        v = {2'b00, mg};
        return sg ? -v : v;
    endfunction

    // Quadrature coordinates above one are used as one.
    assign raw_r  = qp_reg[{cmd.qp, 1'b0}];
    assign raw_s  = qp_reg[{cmd.qp, 1'b1}];
    assign r_val  = (raw_r > ONE_Q16) ? ONE_Q16 : raw_r;
    assign s_val  = (raw_s > ONE_Q16) ? ONE_Q16 : raw_s;
    assign rc_val = ONE_Q16 - r_val;
    assign sc_val = ONE_Q16 - s_val;

    assign ka = cmd.mula_step[3:2];

    always_comb
    begin
        coef_a = '0;
        opd_a  = '0;
        if (ka != 2'd3)
        begin
            case (cmd.mula_step[1:0])
                2'd0:
                begin
                    coef_a = sc_val;
                    opd_a  = {e10_reg[ka][32], e10_reg[ka]};
                end
                2'd1:
                begin
                    coef_a = s_val;
                    opd_a  = {e23_reg[ka][32], e23_reg[ka]};
                end
                2'd2:
                begin
                    coef_a = rc_val;
                    opd_a  = {e30_reg[ka][32], e30_reg[ka]};
                end
                default:
                begin
                    coef_a = r_val;
                    opd_a  = {e21_reg[ka][32], e21_reg[ka]};
                end
            endcase
        end
        else
        begin
            case (cmd.mula_step[1:0])
                2'd0:
                begin
                    coef_a = rc_val;
                    opd_a  = {17'd0, sc_val};
                end
                2'd1:
                begin
                    coef_a = r_val;
                    opd_a  = {17'd0, sc_val};
                end
                2'd2:
                begin
                    coef_a = r_val;
                    opd_a  = {17'd0, s_val};
                end
                default:
                begin
                    coef_a = rc_val;
                    opd_a  = {17'd0, s_val};
                end
            endcase
        end
    end

    assign prod_a   = $signed({1'b0, coef_a}) * opd_a;
    assign prod_rnd = prod_a_reg + 52'sd32768;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            uv[k] = sm32(asg_reg[2*k], am_reg[2*k][29:0]);
            wv[k] = sm32(asg_reg[2*k+1], am_reg[2*k+1][29:0]);
        end
    end

    always_comb
    begin
        op_u = '0;
        op_w = '0;
        if (cmd.sq_go)
        begin
            op_u = {1'b0, cm_reg[cmd.sq_step][30:0]};
            op_w = {1'b0, cm_reg[cmd.sq_step][30:0]};
        end
        else
        begin
            case (cmd.cross_step)
                3'd0:
                begin
                    op_u = uv[1];
                    op_w = wv[2];
                end
                3'd1:
                begin
                    op_u = uv[2];
                    op_w = wv[1];
                end
                3'd2:
                begin
                    op_u = uv[2];
                    op_w = wv[0];
                end
                3'd3:
                begin
                    op_u = uv[0];
                    op_w = wv[2];
                end
                3'd4:
                begin
                    op_u = uv[0];
                    op_w = wv[1];
                end
                default:
                begin
                    op_u = uv[1];
                    op_w = wv[0];
                end
            endcase
        end
    end

    assign prod_b = op_u * op_w;

    always_comb
    begin
        status = '0;
        status.c_zero = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            status.a_big = status.a_big | (|am_reg[i][50:30]);
        end
        status.c_small = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            status.c_big   = status.c_big | (|cm_reg[i][61:31]);
            status.c_small = status.c_small & ~(|cm_reg[i][61:30]);
            status.c_zero  = status.c_zero & (cm_reg[i] == '0);
        end
    end

    qsj_sqrt u_sqrt (
        .clk      (clk),
        .init     (cmd.sqrt_init),
        .step     (cmd.sqrt_step),
        .radicand (sum_reg),
        .root     (root)
    );

    assign div_num = {1'b0, cm_reg[cmd.div_comp][30:0], 30'd0} + 62'(root >> 1);

    qsj_div u_div (
        .clk  (clk),
        .init (cmd.div_init),
        .step (cmd.div_step),
        .num  (div_num),
        .den  (root),
        .quot (quot)
    );

    // The area is the root scaled by 2^(b + 2a - 32), rounded half up on the
    // way down and saturated on the way up.
    always_comb
    begin
        e_val   = $signed({2'b00, a_reg, 1'b0}) + $signed({b_reg[6], b_reg}) - 8'sd32;
        rsh     = 6'(-e_val);
        rnd_sum = {32'd0, root} + (64'd1 << (rsh - 6'd1));
        lsh     = {64'd0, root} << e_val[5:0];
        if (e_val < 8'sd0)
        begin
            area_val = rnd_sum >> rsh;
        end
        else if (e_val == 8'sd0)
        begin
            area_val = {32'd0, root};
        end
        else if ((e_val > 8'sd33) || (lsh[95:64] != '0))
        begin
            area_val = '1;
        end
        else
        begin
            area_val = lsh[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                qp_reg[i] <= QP_RESET[i];
            end
            prod_a_vld_reg <= 1'b0;
            prod_b_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                qp_reg[cfg_index] <= cfg_data;
            end
            prod_a_vld_reg <= cmd.mula_go;
            prod_b_vld_reg <= cmd.cross_go | cmd.sq_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_load)
        begin
            node_reg[node_index][0] <= coord_x;
            node_reg[node_index][1] <= coord_y;
            node_reg[node_index][2] <= coord_z;
        end

        if (cmd.diff_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e10_reg[k] <= {node_reg[1][k][31], node_reg[1][k]}
                            - {node_reg[0][k][31], node_reg[0][k]};
                e23_reg[k] <= {node_reg[2][k][31], node_reg[2][k]}
                            - {node_reg[3][k][31], node_reg[3][k]};
                e30_reg[k] <= {node_reg[3][k][31], node_reg[3][k]}
                            - {node_reg[0][k][31], node_reg[0][k]};
                e21_reg[k] <= {node_reg[2][k][31], node_reg[2][k]}
                            - {node_reg[1][k][31], node_reg[1][k]};
            end
        end

        prod_a_reg      <= prod_a;
        prod_a_step_reg <= cmd.mula_step;
        if (prod_a_vld_reg)
        begin
            if (prod_a_step_reg[3:2] != 2'd3)
            begin
                if (!prod_a_step_reg[0])
                begin
                    dv_reg[{prod_a_step_reg[3:2], prod_a_step_reg[1]}] <= prod_a_reg;
                end
                else
                begin
                    dv_reg[{prod_a_step_reg[3:2], prod_a_step_reg[1]}] <=
                        dv_reg[{prod_a_step_reg[3:2], prod_a_step_reg[1]}] + prod_a_reg;
                end
            end
            else
            begin
                basis_reg[prod_a_step_reg[1:0]] <= prod_rnd[32:16];
            end
        end

        if (cmd.abs_a)
        begin
            for (int i = 0; i < 6; i++)
            begin
                am_reg[i]  <= dv_reg[i][51] ? 51'(-dv_reg[i]) : 51'(dv_reg[i]);
                asg_reg[i] <= dv_reg[i][51];
            end
            a_reg <= '0;
        end
        else if (cmd.shift_a)
        begin
            for (int i = 0; i < 6; i++)
            begin
                am_reg[i] <= am_reg[i] >> 1;
            end
            a_reg <= a_reg + 5'd1;
        end

        prod_b_reg      <= prod_b;
        prod_b_sq_reg   <= cmd.sq_go;
        prod_b_step_reg <= cmd.cross_step;
        if (prod_b_vld_reg)
        begin
            if (prod_b_sq_reg)
            begin
                sum_reg <= sum_reg + prod_b_reg;
            end
            else if (!prod_b_step_reg[0])
            begin
                c_reg[prod_b_step_reg[2:1]] <= prod_b_reg;
            end
            else
            begin
                c_reg[prod_b_step_reg[2:1]] <= c_reg[prod_b_step_reg[2:1]] - prod_b_reg;
            end
        end

        if (cmd.abs_c)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[i]  <= c_reg[i][63] ? 62'(-c_reg[i]) : 62'(c_reg[i]);
                csg_reg[i] <= c_reg[i][63];
            end
            b_reg   <= '0;
            sum_reg <= '0;
        end
        else if (cmd.shr_c)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[i] <= cm_reg[i] >> 1;
            end
            b_reg <= b_reg + 7'sd1;
        end
        else if (cmd.shl_c)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[i] <= cm_reg[i] << 1;
            end
            b_reg <= b_reg - 7'sd1;
        end

        if (cmd.nrm_store)
        begin
            nrm_reg[cmd.div_comp] <= csg_reg[cmd.div_comp] ? -{1'b0, quot} : {1'b0, quot};
        end

        if (cmd.area_go)
        begin
            degen_reg <= status.c_zero;
            if (status.c_zero)
            begin
                area_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    nrm_reg[k] <= '0;
                end
            end
            else
            begin
                area_reg <= area_val;
            end
        end

        if (cmd.out_load)
        begin
            point_index <= cmd.qp;
            basis_0     <= basis_reg[0];
            basis_1     <= basis_reg[1];
            basis_2     <= basis_reg[2];
            basis_3     <= basis_reg[3];
            normal_x    <= nrm_reg[0];
            normal_y    <= nrm_reg[1];
            normal_z    <= nrm_reg[2];
            area_scale  <= area_reg;
            degenerate  <= degen_reg;
            last        <= cmd.last;
        end
    end

endmodule

// ----- hw/rtl/qsj_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences node loads and the per-point work.
// Depends on qsj_pkg for the command and status types.
module qsj_ctrl
    import qsj_pkg::*;
#(
    parameter int NUM_QP = QSJ_NUM_QP
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   node_index,
    output logic         out_valid,
    input  logic         out_ready,
    input  qsj_status_t  status,
    output qsj_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MULA,
        S_ABSA,
        S_SHA,
        S_CROSS,
        S_ABSC,
        S_SHB,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_AREA,
        S_OUT
    } state_t;

    state_t     state_reg;
    logic [5:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [1:0] qp_reg;
    logic       out_valid_reg;
    logic       slot_free;
    logic       last_qp;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_qp   = qp_reg == 2'(NUM_QP - 1);
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.qp         = qp_reg;
        cmd.last       = last_qp;
        cmd.mula_step  = cnt_reg[3:0];
        cmd.cross_step = cnt_reg[2:0];
        cmd.sq_step    = cnt_reg[1:0];
        cmd.div_comp   = comp_reg;
        unique case (state_reg)
            S_IDLE:  cmd.node_load = in_valid;
            S_DIFF:  cmd.diff_load = 1'b1;
            S_MULA:  cmd.mula_go   = cnt_reg < 6'(MULA_STEPS);
            S_ABSA:  cmd.abs_a     = 1'b1;
            S_SHA:   cmd.shift_a   = status.a_big;
            S_CROSS: cmd.cross_go  = cnt_reg < 6'(CROSS_STEPS);
            S_ABSC:  cmd.abs_c     = 1'b1;
            S_SHB:
            begin
                cmd.shr_c = !status.c_zero && status.c_big;
                cmd.shl_c = !status.c_zero && !status.c_big && status.c_small;
            end
            S_SQ:    cmd.sq_go     = cnt_reg < 6'(SQ_STEPS);
            S_SQRT:
            begin
                cmd.sqrt_init = cnt_reg == '0;
                cmd.sqrt_step = cnt_reg != '0;
            end
            S_DIV:
            begin
                cmd.div_init  = cnt_reg == '0;
                cmd.div_step  = (cnt_reg != '0) && (cnt_reg <= 6'(DIV_STEPS));
                cmd.nrm_store = cnt_reg == 6'(DIV_STEPS + 1);
            end
            S_AREA:  cmd.area_go   = 1'b1;
            S_OUT:   cmd.out_load  = slot_free;
            default: cmd.diff_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            qp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (node_index == 2'd3))
                    begin
                        state_reg <= S_DIFF;
                        qp_reg    <= '0;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_MULA;
                    cnt_reg   <= '0;
                end
                S_MULA:
                begin
                    if (cnt_reg == 6'(MULA_STEPS))
                    begin
                        state_reg <= S_ABSA;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_ABSA:  state_reg <= S_SHA;
                S_SHA:
                begin
                    if (!status.a_big)
                    begin
                        state_reg <= S_CROSS;
                        cnt_reg   <= '0;
                    end
                end
                S_CROSS:
                begin
                    if (cnt_reg == 6'(CROSS_STEPS))
                    begin
                        state_reg <= S_ABSC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_ABSC:  state_reg <= S_SHB;
                S_SHB:
                begin
                    if (status.c_zero)
                    begin
                        state_reg <= S_AREA;
                    end
                    else if (!status.c_big && !status.c_small)
                    begin
                        state_reg <= S_SQ;
                        cnt_reg   <= '0;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == 6'(SQ_STEPS))
                    begin
                        state_reg <= S_SQRT;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == 6'(SQRT_STEPS))
                    begin
                        state_reg <= S_DIV;
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'(DIV_STEPS + 1))
                    begin
                        cnt_reg <= '0;
                        if (comp_reg == 2'(LAST_COMP))
                        begin
                            state_reg <= S_AREA;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_AREA:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        qp_reg  <= qp_reg + 2'd1;
                        cnt_reg <= '0;
                        state_reg <= last_qp ? S_IDLE : S_MULA;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/quad_surface_jacobian_normal.sv -----
`timescale 1ns / 1ps
// Bilinear quadrilateral surface element: takes four corner nodes one beat at
// a time; a node with index 3 starts NUM_QP result beats, one per quadrature
// point, each carrying the basis values, the unit normal in Q2.30 and the
// surface Jacobian in Q32.32. Nodes 0 to 2 are only stored. The normalizing
// shifts a (0 to 18) and b (-30 to 30) of the derivatives and of the cross
// product are done one bit per cycle; the three divides and the square root
// dominate the work for a point. A degenerate point skips those units. Node
// inputs are refused while points are being worked; a finished result waits
// in the output register.
// Depends on qsj_pkg, qsj_ctrl and qsj_dp.
module quad_surface_jacobian_normal
    import qsj_pkg::*;
#(
    parameter int NUM_QP = QSJ_NUM_QP
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [QP_W-1:0]       cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            node_index,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            point_index,
    output logic [QP_W-1:0]       basis_0,
    output logic [QP_W-1:0]       basis_1,
    output logic [QP_W-1:0]       basis_2,
    output logic [QP_W-1:0]       basis_3,
    output logic signed [31:0]    normal_x,
    output logic signed [31:0]    normal_y,
    output logic signed [31:0]    normal_z,
    output logic [63:0]           area_scale,
    output logic                  degenerate,
    output logic                  last
);

    qsj_cmd_t    cmd;
    qsj_status_t status;

    assign cfg_ready = 1'b1;

    qsj_ctrl #(
        .NUM_QP (NUM_QP)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .node_index (node_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    qsj_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .node_index  (node_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cmd         (cmd),
        .status      (status),
        .point_index (point_index),
        .basis_0     (basis_0),
        .basis_1     (basis_1),
        .basis_2     (basis_2),
        .basis_3     (basis_3),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .area_scale  (area_scale),
        .degenerate  (degenerate),
        .last        (last)
    );

endmodule

// ----- hw/rtl/qsj_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the quad surface Jacobian block, bound to the top.
// Depends on quad_surface_jacobian_normal.
module qsj_checker #(
    parameter int NUM_QP = 4
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         node_index,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         point_index,
    input logic signed [31:0] normal_x,
    input logic signed [31:0] normal_y,
    input logic signed [31:0] normal_z,
    input logic [63:0]        area_scale,
    input logic               degenerate,
    input logic               last
);

    // A corner-3 beat starts the point sequence, so no node is taken next.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (node_index == 2'd3) |=> !in_ready)
        else $error("node accepted right after the closing corner");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            (normal_x == 0) && (normal_y == 0) && (normal_z == 0) && (area_scale == 0))
        else $error("degenerate result with nonzero normal or area");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> point_index == 2'(NUM_QP - 1))
        else $error("last flag on the wrong point");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_index) && $stable(area_scale))
        else $error("stalled result beat changed");

endmodule

bind quad_surface_jacobian_normal qsj_checker #(.NUM_QP(NUM_QP)) u_qsj_checker (.*);

// ----- dv/quad_surface_jacobian_normal_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of quad_surface_jacobian_normal: loads corner nodes, predicts
// the basis values, unit normal and area of every quadrature point, and compares each beat.
// Depends on qsj_pkg and the RTL of the block; reads no files.
module quad_surface_jacobian_normal_test;
    import qsj_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        QP0_R, QP0_S, QP1_R, QP1_S, QP2_R, QP2_S, QP3_R, QP3_S
    } qp_reg_e;

    typedef struct {
        logic [1:0]        point_index;
        logic [QP_W-1:0]   basis [4];
        logic [31:0]       normal [3];
        logic [63:0]       area_scale;
        logic              degenerate;
        logic              last;
    } point_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [QP_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           node_index;
    logic signed [31:0]   coord_x;
    logic signed [31:0]   coord_y;
    logic signed [31:0]   coord_z;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           point_index;
    logic [QP_W-1:0]      basis_0;
    logic [QP_W-1:0]      basis_1;
    logic [QP_W-1:0]      basis_2;
    logic [QP_W-1:0]      basis_3;
    logic signed [31:0]   normal_x;
    logic signed [31:0]   normal_y;
    logic signed [31:0]   normal_z;
    logic [63:0]          area_scale;
    logic                 degenerate;
    logic                 last;

    logic signed [31:0] node_xyz [4][3];
    logic [QP_W-1:0]    qp_mirror [NUM_CFG];
    point_res_t         expected_points [$];
    int                 fails;
    bit                 quiet;
    int                 stall_left;
    int                 idle_cycles;

    quad_surface_jacobian_normal dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint shift_mag(longint v, int sh);
        logic [63:0] m;
        m = mag(v);
        if (sh > 0) m = m >> sh;
        else m = m << (-sh);
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [QP_W-1:0] mul_q16(longint a, longint b);
        return QP_W'((a * b + 32768) >> 16);
    endfunction

    function automatic point_res_t surface_point(int q);
        point_res_t rs;
        longint r, s, rc, sc;
        longint dr [3], ds [3], u [3], w [3], c [3], d [3], p [4], nrm [3];
        logic [63:0] mu, mc, sum, m, qv, area;
        int a, b, e;
        r = qp_mirror[2*q] > ONE_Q16 ? 65536 : longint'(qp_mirror[2*q]);
        s = qp_mirror[2*q+1] > ONE_Q16 ? 65536 : longint'(qp_mirror[2*q+1]);
        rc = 65536 - r;
        sc = 65536 - s;
        mu = 0;
        mc = 0;
        area = 0;
        a = 0;
        b = 0;
        for (int k = 0; k < 3; k++) begin
            nrm[k] = 0;
            for (int i = 0; i < 4; i++) p[i] = longint'(node_xyz[i][k]);
            dr[k] = sc * (p[1] - p[0]) + s * (p[2] - p[3]);
            ds[k] = rc * (p[3] - p[0]) + r * (p[2] - p[1]);
            if (mag(dr[k]) > mu) mu = mag(dr[k]);
            if (mag(ds[k]) > mu) mu = mag(ds[k]);
        end
        while ((mu >> a) >= (64'd1 << 30)) a++;
        for (int k = 0; k < 3; k++) begin
            u[k] = shift_mag(dr[k], a);
            w[k] = shift_mag(ds[k], a);
        end
        c[0] = u[1] * w[2] - u[2] * w[1];
        c[1] = u[2] * w[0] - u[0] * w[2];
        c[2] = u[0] * w[1] - u[1] * w[0];
        for (int k = 0; k < 3; k++)
            if (mag(c[k]) > mc) mc = mag(c[k]);
        rs.degenerate = (mc == 0);
        if (mc != 0) begin
            sum = 0;
            while ((mc >> b) >= (64'd1 << 31)) b++;
            if (b == 0)
                while ((mc << (-b)) < (64'd1 << 30)) b--;
            for (int k = 0; k < 3; k++) begin
                d[k] = shift_mag(c[k], b);
                sum = sum + mag(d[k]) * mag(d[k]);
            end
            m = int_sqrt(sum);
            for (int k = 0; k < 3; k++) begin
                qv = ((mag(d[k]) << 30) + (m >> 1)) / m;
                nrm[k] = d[k] < 0 ? -longint'(qv) : longint'(qv);
            end
            e = b + 2 * a - 32;
            if (e < 0) area = (m + (64'd1 << (-e - 1))) >> (-e);
            else if (e == 0) area = m;
            else if ((m >> (64 - e)) != 0) area = '1;
            else area = m << e;
        end
        rs.point_index = q[1:0];
        rs.basis[0] = mul_q16(rc, sc);
        rs.basis[1] = mul_q16(r, sc);
        rs.basis[2] = mul_q16(r, s);
        rs.basis[3] = mul_q16(rc, s);
        for (int k = 0; k < 3; k++) rs.normal[k] = nrm[k][31:0];
        rs.area_scale = area;
        rs.last = (q == QSJ_NUM_QP - 1);
        return rs;
    endfunction

    task automatic send_node(input logic [1:0] idx, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        node_index <= idx;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        do @(posedge clk); while (!in_ready);
        node_xyz[idx][0] = x;
        node_xyz[idx][1] = y;
        node_xyz[idx][2] = z;
        if (idx == 2'd3)
            for (int q = 0; q < QSJ_NUM_QP; q++) expected_points.push_back(surface_point(q));
    endtask

    task automatic send_element(input logic signed [31:0] pts [4][3]);
        for (int i = 0; i < 4; i++) send_node(i[1:0], pts[i][0], pts[i][1], pts[i][2]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_quad_points(input logic [QP_W-1:0] vals [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= qp_reg_e'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            qp_mirror[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2097151)) - 1048576;
            2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            3: return $signed($urandom_range(0, 511)) - 256;
            default: return $signed($urandom_range(0, 33554431)) - 16777216;
        endcase
    endfunction

    task automatic test_default_points();
        logic signed [31:0] el [4][3];
        el = '{'{0, 0, 0}, '{65536, 0, 0}, '{65536, 65536, 0}, '{0, 65536, 0}};
        send_element(el);
        el = '{'{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF},
               '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000},
               '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
               '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000}};
        send_element(el);
        el = '{'{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}};
        send_element(el);
        el = '{'{0, 0, 0}, '{1, 2, 3}, '{2, 4, 6}, '{1, 2, 3}};
        send_element(el);
        send_node(2'd3, 1, -1, 7);
        send_node(2'd3, 32'sh7FFFFFFF, 32'sh80000000, 0);
        el = '{'{0, 0, 0}, '{1, 0, 0}, '{1, 1, 1}, '{0, 1, 0}};
        send_element(el);
    endtask

    task automatic test_edge_points();
        logic [QP_W-1:0] vals [NUM_CFG];
        logic signed [31:0] el [4][3];
        el = '{'{-65536, 3000, 100}, '{70000, -200, 50}, '{60000, 80000, -9000},
               '{-1000, 65536, 777}};
        drain_results();
        vals = '{0, 0, 0, 0, 0, 0, 0, 0};
        write_quad_points(vals);
        send_element(el);
        drain_results();
        vals = '{17'd65536, 17'd65536, 17'd65536, 17'd65536,
                 17'd65536, 17'd65536, 17'd65536, 17'd65536};
        write_quad_points(vals);
        send_element(el);
        drain_results();
        vals = '{17'd131071, 17'd0, 17'd0, 17'd131071, 17'd65537, 17'd100000,
                 17'd1, 17'd65535};
        write_quad_points(vals);
        send_element(el);
    endtask

    task automatic test_random_elements();
        logic [QP_W-1:0] vals [NUM_CFG];
        logic signed [31:0] el [4][3];
        int sent;
        sent = 0;
        while (sent < 128) begin
            if (sent % 35 == 0) begin
                drain_results();
                for (int i = 0; i < NUM_CFG; i++)
                    vals[i] = $urandom_range(0, 3) == 0 ? QP_W'($urandom)
                                                        : QP_W'($urandom_range(0, 65536));
                write_quad_points(vals);
            end
            if (sent >= 108) quiet = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 4; i++)
                    for (int k = 0; k < 3; k++) el[i][k] = rand_coord();
                if ($urandom_range(0, 7) == 0) el[2] = el[1];
                if ($urandom_range(0, 7) == 0) el = '{el[0], el[0], el[0], el[0]};
                send_element(el);
                sent += 4;
            end else begin
                send_node(2'($urandom), rand_coord(), rand_coord(), rand_coord());
                sent += 1;
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk) begin
        point_res_t ex;
        if (rst_n && out_valid && out_ready) begin
            if (expected_points.size() == 0) begin
                $error("result beat with no expected point");
                fails++;
            end else begin
                ex = expected_points.pop_front();
                check_field("point_index", ex.point_index, point_index);
                check_field("basis_0", ex.basis[0], basis_0);
                check_field("basis_1", ex.basis[1], basis_1);
                check_field("basis_2", ex.basis[2], basis_2);
                check_field("basis_3", ex.basis[3], basis_3);
                check_field("normal_x", ex.normal[0], $unsigned(normal_x));
                check_field("normal_y", ex.normal[1], $unsigned(normal_y));
                check_field("normal_z", ex.normal[2], $unsigned(normal_z));
                check_field("area_scale", ex.area_scale, area_scale);
                check_field("degenerate", ex.degenerate, degenerate);
                check_field("last", ex.last, last);
            end
        end
    end

    always @(posedge clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        node_index <= '0;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
        out_ready <= 1'b0;
        fails = 0;
        quiet = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        for (int i = 0; i < NUM_CFG; i++) qp_mirror[i] = QP_RESET[i];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_points();
        test_edge_points();
        test_random_elements();
        drain_results();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
